/* src/fcvm_pkg.sv */
// ----------------------------------------------------------------------------
// Fly camera view matrix package
// Shared types, fixed-point constants and arithmetic helpers.
// ----------------------------------------------------------------------------
package fcvm_pkg;

	localparam int AngleFracBits = 7;
	localparam int VecFracBits = 14;

	localparam logic [15:0] FullTurn = 16'(360 << AngleFracBits);
	localparam logic [15:0] QuarterTurn = 16'(90 << AngleFracBits);
	localparam logic [15:0] YawReset = 16'(270 << AngleFracBits);
	localparam logic [31:0] RadPerDegQ30 = 32'd18740330;
	localparam logic [30:0] Q30One = 31'h4000_0000;

	localparam logic [1:0] RowLast = 2'd2;

	typedef logic signed [32:0] mop_t;
	typedef logic signed [65:0] prod_t;
	typedef logic signed [15:0] vec_t;
	typedef logic signed [31:0] pos_t;

	localparam vec_t VecOne = 16'(1 << VecFracBits);
	localparam pos_t PosZReset = 32'(15 << 16);
	localparam prod_t PosMax = 66'sd2147483647;
	localparam prod_t PosMin = -66'sd2147483648;

	function automatic prod_t round_vec(prod_t p);
		logic neg;
		prod_t m;
		neg = p[65];
		m = neg ? -p : p;
		m = (m + prod_t'(1 << (VecFracBits - 1))) >>> VecFracBits;
		return neg ? -m : m;
	endfunction

	function automatic pos_t sat32(prod_t v);
		if (v > PosMax) return pos_t'(PosMax);
		if (v < PosMin) return pos_t'(PosMin);
		return pos_t'(v);
	endfunction

	function automatic vec_t to_vec(logic [31:0] v);
		logic [31:0] s;
		s = (v + 32'(1 << (29 - VecFracBits))) >> (30 - VecFracBits);
		return vec_t'(s[15:0]);
	endfunction

	function automatic logic [7:0] series_div(logic cos_sel, logic [2:0] i);
		case ({cos_sel, i})
			4'b0000: return 8'd110;
			4'b0001: return 8'd72;
			4'b0010: return 8'd42;
			4'b0011: return 8'd20;
			4'b0100: return 8'd6;
			4'b1000: return 8'd132;
			4'b1001: return 8'd90;
			4'b1010: return 8'd56;
			4'b1011: return 8'd30;
			4'b1100: return 8'd12;
			4'b1101: return 8'd2;
			default: return 8'd1;
		endcase
	endfunction

	// Floor of 2^32 over the divisor; the quotient needs at most one correction.
	function automatic logic [31:0] series_recip(logic cos_sel, logic [2:0] i);
		case ({cos_sel, i})
			4'b0000: return 32'd39045157;
			4'b0001: return 32'd59652323;
			4'b0010: return 32'd102261126;
			4'b0011: return 32'd214748364;
			4'b0100: return 32'd715827882;
			4'b1000: return 32'd32537631;
			4'b1001: return 32'd47721858;
			4'b1010: return 32'd76695844;
			4'b1011: return 32'd143165576;
			4'b1100: return 32'd357913941;
			4'b1101: return 32'd2147483648;
			default: return 32'hFFFF_FFFF;
		endcase
	endfunction

endpackage

/* src/fcvm_if.sv */
// ----------------------------------------------------------------------------
// Fly camera view matrix channels
// Valid/ready channels for command words and matrix row words.
// ----------------------------------------------------------------------------
interface fcvm_in_if;
	logic valid;
	logic ready;
	logic kind;
	logic [1:0] which_axis;
	logic signed [16:0] angle_delta;
	logic signed [31:0] move_amount;

	modport source(output valid, kind, which_axis, angle_delta, move_amount, input ready);
	modport sink(input valid, kind, which_axis, angle_delta, move_amount, output ready);
endinterface

interface fcvm_out_if;
	logic valid;
	logic ready;
	logic [1:0] row_index;
	logic signed [15:0] coef_x;
	logic signed [15:0] coef_y;
	logic signed [15:0] coef_z;
	logic signed [31:0] translation;
	logic degenerate;
	logic last_row;

	modport source(output valid, row_index, coef_x, coef_y, coef_z, translation, degenerate,
		last_row, input ready);
	modport sink(input valid, row_index, coef_x, coef_y, coef_z, translation, degenerate,
		last_row, output ready);
endinterface

/* src/fcvm_mul.sv */
// ----------------------------------------------------------------------------
// Fly camera shared multiplier
// Signed 33 by 33 multiplier with a registered product.
// ----------------------------------------------------------------------------
module fcvm_mul import fcvm_pkg::*; (
	input logic clk,
	input mop_t a,
	input mop_t b,
	output prod_t prod_q
);

	always_ff @(posedge clk) begin
		prod_q <= a * b;
	end

endmodule

/* src/fly_camera_view_matrix_unit.sv */
// ----------------------------------------------------------------------------
// Fly camera view matrix unit
// Euler-angle camera that emits the three rows of its view matrix per command.
// ----------------------------------------------------------------------------
// Each command word rotates (yaw or pitch), moves the camera or changes nothing
// (roll rotate, or no axis); the basis is then rebuilt and three row words
// (right, up, negated front) follow. All products run through one registered
// multiplier under a sequencer; most of the work is the two sine/cosine series
// of eleven divide steps each. The command port is not ready until the last
// row word has been taken.
module fly_camera_view_matrix_unit import fcvm_pkg::*; (
	input logic clk,
	input logic arst_n,
	fcvm_in_if.sink cmd,
	fcvm_out_if.source row
);

	typedef enum logic [14:0] {
		ST_IDLE   = 15'b000000000000001,
		ST_ANGLE  = 15'b000000000000010,
		ST_MOVE   = 15'b000000000000100,
		ST_TSTART = 15'b000000000001000,
		ST_QUAD   = 15'b000000000010000,
		ST_X      = 15'b000000000100000,
		ST_X2     = 15'b000000001000000,
		ST_P      = 15'b000000010000000,
		ST_Q0     = 15'b000000100000000,
		ST_CORR   = 15'b000001000000000,
		ST_SINF   = 15'b000010000000000,
		ST_BASIS  = 15'b000100000000000,
		ST_BMUL   = 15'b001000000000000,
		ST_ROWS   = 15'b010000000000000,
		ST_OUT    = 15'b100000000000000
	} fcvm_state_t;

	fcvm_state_t state_q;
	logic ph_q;
	logic [1:0] axis_q;
	pos_t amount_q;
	logic [15:0] yaw_q;
	logic [15:0] pitch_q;
	logic signed [17:0] acc_q;
	pos_t pos_q [3];
	vec_t basis_q [9];
	logic degen_q;
	logic negc_q;
	logic [1:0] idx_q;
	logic [1:0] k_q;
	logic [1:0] bi_q;
	logic sel_q;
	logic [15:0] r_q;
	logic [1:0] quad_q;
	logic [30:0] x_q;
	logic [31:0] x2_q;
	logic [30:0] t_q;
	logic [31:0] p_q;
	logic [31:0] q0_q;
	logic [2:0] ser_q;
	logic cosph_q;
	vec_t sv_q;
	vec_t sy_q, cy_q, sp_q, cp_q;
	logic signed [47:0] dot_q;
	pos_t trans_q [3];

	mop_t mul_a, mul_b;
	prod_t prod;
	prod_t rv;
	vec_t cur_row [3];
	logic [3:0] mv_idx;
	prod_t rem;
	logic corr;
	logic [32:0] d_val;
	logic [30:0] t_next;
	vec_t cv_new;
	vec_t s_new, c_new;
	logic signed [47:0] dot_next;

	fcvm_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .prod_q(prod));

	always_comb begin
		case (k_q)
			2'd0: begin
				cur_row[0] = basis_q[3];
				cur_row[1] = basis_q[4];
				cur_row[2] = basis_q[5];
			end
			2'd1: begin
				cur_row[0] = basis_q[6];
				cur_row[1] = basis_q[7];
				cur_row[2] = basis_q[8];
			end
			default: begin
				cur_row[0] = -basis_q[0];
				cur_row[1] = -basis_q[1];
				cur_row[2] = -basis_q[2];
			end
		endcase
	end

	assign mv_idx = 4'(axis_q) * 4'd3 + 4'(idx_q);

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			ST_MOVE: begin
				mul_a = mop_t'(amount_q);
				mul_b = mop_t'(basis_q[mv_idx]);
			end
			ST_X: begin
				mul_a = mop_t'({17'b0, r_q});
				mul_b = mop_t'({1'b0, RadPerDegQ30});
			end
			ST_X2: begin
				mul_a = mop_t'({2'b0, x_q});
				mul_b = mop_t'({2'b0, x_q});
			end
			ST_P: begin
				mul_a = mop_t'({1'b0, x2_q});
				mul_b = mop_t'({2'b0, t_q});
			end
			ST_Q0: begin
				mul_a = mop_t'({1'b0, p_q});
				mul_b = mop_t'({1'b0, series_recip(cosph_q, ser_q)});
			end
			ST_CORR: begin
				mul_a = mop_t'({1'b0, q0_q});
				mul_b = mop_t'({25'b0, series_div(cosph_q, ser_q)});
			end
			ST_SINF: begin
				mul_a = mop_t'({2'b0, x_q});
				mul_b = mop_t'({2'b0, t_q});
			end
			ST_BMUL: begin
				mul_a = mop_t'(bi_q[0] ? sy_q : cy_q);
				mul_b = mop_t'(bi_q[1] ? sp_q : cp_q);
			end
			ST_ROWS: begin
				mul_a = mop_t'(cur_row[idx_q]);
				mul_b = mop_t'(pos_q[idx_q]);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	always_comb begin
		rv = round_vec(prod);
		rem = prod_t'({34'b0, p_q}) - prod;
		corr = rem >= prod_t'({58'b0, series_div(cosph_q, ser_q)});
		d_val = {1'b0, q0_q} + 33'(corr);
		t_next = (d_val > {2'b0, Q30One}) ? '0 : 31'({2'b0, Q30One} - d_val);
		cv_new = to_vec({1'b0, t_next});
		case (quad_q)
			2'd0: begin
				s_new = sv_q;
				c_new = cv_new;
			end
			2'd1: begin
				s_new = cv_new;
				c_new = -sv_q;
			end
			2'd2: begin
				s_new = -sv_q;
				c_new = -cv_new;
			end
			default: begin
				s_new = -cv_new;
				c_new = sv_q;
			end
		endcase
		dot_next = dot_q + 48'(prod);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ph_q <= 1'b0;
			axis_q <= '0;
			amount_q <= '0;
			yaw_q <= YawReset;
			pitch_q <= '0;
			acc_q <= '0;
			pos_q[0] <= '0;
			pos_q[1] <= '0;
			pos_q[2] <= PosZReset;
			basis_q[0] <= '0;
			basis_q[1] <= '0;
			basis_q[2] <= -VecOne;
			basis_q[3] <= VecOne;
			basis_q[4] <= '0;
			basis_q[5] <= '0;
			basis_q[6] <= '0;
			basis_q[7] <= VecOne;
			basis_q[8] <= '0;
			degen_q <= 1'b0;
			negc_q <= 1'b0;
			idx_q <= '0;
			k_q <= '0;
			bi_q <= '0;
			sel_q <= 1'b0;
			r_q <= '0;
			quad_q <= '0;
			x_q <= '0;
			x2_q <= '0;
			t_q <= '0;
			p_q <= '0;
			q0_q <= '0;
			ser_q <= '0;
			cosph_q <= 1'b0;
			sv_q <= '0;
			sy_q <= '0;
			cy_q <= '0;
			sp_q <= '0;
			cp_q <= '0;
			dot_q <= '0;
			for (int i = 0; i < 3; i++) trans_q[i] <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (cmd.valid) begin
						axis_q <= cmd.which_axis;
						amount_q <= cmd.move_amount;
						ph_q <= 1'b0;
						idx_q <= '0;
						acc_q <= $signed({2'b00, (cmd.which_axis[0] ? pitch_q : yaw_q)})
							+ 18'(cmd.angle_delta);
						if (!cmd.kind && !cmd.which_axis[1]) begin
							state_q <= ST_ANGLE;
						end else if (cmd.kind && cmd.which_axis != 2'd3) begin
							state_q <= ST_MOVE;
						end else begin
							state_q <= ST_TSTART;
						end
					end
				end
				ST_ANGLE: begin
					if (acc_q < 0) begin
						acc_q <= acc_q + $signed({2'b00, FullTurn});
					end else if (acc_q >= $signed({2'b00, FullTurn})) begin
						acc_q <= acc_q - $signed({2'b00, FullTurn});
					end else begin
						if (axis_q[0]) pitch_q <= acc_q[15:0];
						else yaw_q <= acc_q[15:0];
						state_q <= ST_TSTART;
					end
				end
				ST_MOVE: begin
					ph_q <= !ph_q;
					if (ph_q) begin
						pos_q[idx_q] <= sat32(prod_t'(pos_q[idx_q]) + rv);
						if (idx_q == 2'd2) begin
							idx_q <= '0;
							state_q <= ST_TSTART;
						end else begin
							idx_q <= idx_q + 2'd1;
						end
					end
				end
				ST_TSTART: begin
					r_q <= yaw_q;
					quad_q <= '0;
					sel_q <= 1'b0;
					state_q <= ST_QUAD;
				end
				ST_QUAD: begin
					if (r_q >= QuarterTurn) begin
						r_q <= r_q - QuarterTurn;
						quad_q <= quad_q + 2'd1;
					end else begin
						ph_q <= 1'b0;
						state_q <= ST_X;
					end
				end
				ST_X: begin
					ph_q <= !ph_q;
					if (ph_q) begin
						x_q <= prod[AngleFracBits +: 31];
						state_q <= ST_X2;
					end
				end
				ST_X2: begin
					ph_q <= !ph_q;
					if (ph_q) begin
						x2_q <= prod[61:30];
						t_q <= Q30One;
						ser_q <= '0;
						cosph_q <= 1'b0;
						state_q <= ST_P;
					end
				end
				ST_P: begin
					ph_q <= !ph_q;
					if (ph_q) begin
						p_q <= prod[61:30];
						state_q <= ST_Q0;
					end
				end
				ST_Q0: begin
					ph_q <= !ph_q;
					if (ph_q) begin
						q0_q <= prod[63:32];
						state_q <= ST_CORR;
					end
				end
				ST_CORR: begin
					ph_q <= !ph_q;
					if (ph_q) begin
						t_q <= t_next;
						if (!cosph_q && ser_q == 3'd4) begin
							state_q <= ST_SINF;
						end else if (cosph_q && ser_q == 3'd5) begin
							if (sel_q) begin
								sp_q <= s_new;
								cp_q <= c_new;
								state_q <= ST_BASIS;
							end else begin
								sy_q <= s_new;
								cy_q <= c_new;
								sel_q <= 1'b1;
								r_q <= pitch_q;
								quad_q <= '0;
								state_q <= ST_QUAD;
							end
						end else begin
							ser_q <= ser_q + 3'd1;
							state_q <= ST_P;
						end
					end
				end
				ST_SINF: begin
					ph_q <= !ph_q;
					if (ph_q) begin
						sv_q <= to_vec(prod[61:30]);
						t_q <= Q30One;
						ser_q <= '0;
						cosph_q <= 1'b1;
						state_q <= ST_P;
					end
				end
				ST_BASIS: begin
					ph_q <= 1'b0;
					bi_q <= '0;
					idx_q <= '0;
					k_q <= '0;
					dot_q <= '0;
					if (cp_q == 0) begin
						degen_q <= 1'b1;
						state_q <= ST_ROWS;
					end else begin
						degen_q <= 1'b0;
						negc_q <= cp_q[15];
						basis_q[1] <= sp_q;
						basis_q[3] <= cp_q[15] ? sy_q : -sy_q;
						basis_q[4] <= '0;
						basis_q[5] <= cp_q[15] ? -cy_q : cy_q;
						basis_q[7] <= cp_q[15] ? -cp_q : cp_q;
						state_q <= ST_BMUL;
					end
				end
				ST_BMUL: begin
					ph_q <= !ph_q;
					if (ph_q) begin
						case (bi_q)
							2'd0: basis_q[0] <= vec_t'(rv);
							2'd1: basis_q[2] <= vec_t'(rv);
							2'd2: basis_q[6] <= negc_q ? vec_t'(rv) : -vec_t'(rv);
							default: basis_q[8] <= negc_q ? vec_t'(rv) : -vec_t'(rv);
						endcase
						if (bi_q == 2'd3) state_q <= ST_ROWS;
						bi_q <= bi_q + 2'd1;
					end
				end
				ST_ROWS: begin
					ph_q <= !ph_q;
					if (ph_q) begin
						if (idx_q == 2'd2) begin
							trans_q[k_q] <= sat32(-round_vec(prod_t'(dot_next)));
							dot_q <= '0;
							idx_q <= '0;
							if (k_q == RowLast) begin
								k_q <= '0;
								state_q <= ST_OUT;
							end else begin
								k_q <= k_q + 2'd1;
							end
						end else begin
							dot_q <= dot_next;
							idx_q <= idx_q + 2'd1;
						end
					end
				end
				ST_OUT: begin
					if (row.ready) begin
						if (k_q == RowLast) begin
							k_q <= '0;
							state_q <= ST_IDLE;
						end else begin
							k_q <= k_q + 2'd1;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign cmd.ready = (state_q == ST_IDLE);
	assign row.valid = (state_q == ST_OUT);
	assign row.row_index = k_q;
	assign row.coef_x = cur_row[0];
	assign row.coef_y = cur_row[1];
	assign row.coef_z = cur_row[2];
	assign row.translation = trans_q[k_q];
	assign row.degenerate = degen_q;
	assign row.last_row = (k_q == RowLast);

endmodule

/* src/fcvm_checker.sv */
// ----------------------------------------------------------------------------
// Fly camera view matrix checker
// Port-level properties of the command and row word channels.
// ----------------------------------------------------------------------------
module fcvm_checker import fcvm_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input logic [1:0] row_index,
	input logic degenerate,
	input logic last_row
);

	a_busy_while_emitting: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid)) else $error("command port ready while rows pending");

	a_last_row_flag: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (last_row == (row_index == RowLast))) else $error("last_row mismatch");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready) else $error("ready held after command accept");

	a_row_order: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !last_row |=>
		out_valid && row_index == $past(row_index) + 2'd1) else $error("row order broken");

	a_degenerate_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && $past(out_valid) |-> $stable(degenerate))
		else $error("degenerate changed within a run");

endmodule

bind fly_camera_view_matrix_unit fcvm_checker u_fcvm_checker (
	.clk(clk),
	.arst_n(arst_n),
	.in_valid(cmd.valid),
	.in_ready(cmd.ready),
	.out_valid(row.valid),
	.out_ready(row.ready),
	.row_index(row.row_index),
	.degenerate(row.degenerate),
	.last_row(row.last_row)
);

/* dv/fly_camera_view_matrix_unit_tb.sv */
// ----------------------------------------------------------------------------
// Fly camera view matrix unit testbench
// Drives rotate and move command words and checks every row word against a
// bit-exact model of the camera basis, position and view matrix rows.
// ----------------------------------------------------------------------------
module fly_camera_view_matrix_unit_tb import fcvm_pkg::*;;

	typedef enum logic {KIND_ROTATE = 1'b0, KIND_MOVE = 1'b1} kind_e;
	typedef enum logic [1:0] {
		AXIS_YAW_FWD = 2'd0, AXIS_PITCH_RIGHT = 2'd1, AXIS_ROLL_UP = 2'd2, AXIS_NONE = 2'd3
	} axis_e;

	typedef struct {
		logic [1:0] row_index;
		vec_t coef_x;
		vec_t coef_y;
		vec_t coef_z;
		pos_t translation;
		logic degenerate;
		logic last_row;
	} row_word_t;

	typedef struct {
		kind_e kind;
		axis_e axis;
		int delta;
		int amount;
		bit known;
		bit degen;
		int back_trans;
	} cmd_step_t;

	localparam int NumDirected = 20;
	localparam int NumRandom = 450;
	localparam int CycleLimit = 1500000;
	localparam int Turn = 360 << AngleFracBits;
	localparam int Quarter = 90 << AngleFracBits;

	cmd_step_t directed [NumDirected] = '{
		'{KIND_ROTATE, AXIS_ROLL_UP, 0, 0, 1, 0, -983040},
		'{KIND_ROTATE, AXIS_NONE, 777, 0, 1, 0, -983040},
		'{KIND_MOVE, AXIS_NONE, 0, 12345, 1, 0, -983040},
		'{KIND_ROTATE, AXIS_PITCH_RIGHT, Quarter, 0, 1, 1, -983040},
		'{KIND_MOVE, AXIS_YAW_FWD, 0, 65536, 0, 0, 0},
		'{KIND_ROTATE, AXIS_PITCH_RIGHT, -Quarter, 0, 0, 0, 0},
		'{KIND_ROTATE, AXIS_PITCH_RIGHT, -Quarter, 0, 1, 1, -917504},
		'{KIND_ROTATE, AXIS_PITCH_RIGHT, Quarter, 0, 0, 0, 0},
		'{KIND_MOVE, AXIS_YAW_FWD, 0, -2147483648, 0, 0, 0},
		'{KIND_MOVE, AXIS_YAW_FWD, 0, -2147483648, 0, 0, 0},
		'{KIND_MOVE, AXIS_YAW_FWD, 0, 2147483647, 0, 0, 0},
		'{KIND_MOVE, AXIS_PITCH_RIGHT, 0, 2147483647, 0, 0, 0},
		'{KIND_MOVE, AXIS_PITCH_RIGHT, 0, 2147483647, 0, 0, 0},
		'{KIND_MOVE, AXIS_ROLL_UP, 0, -2147483648, 0, 0, 0},
		'{KIND_ROTATE, AXIS_YAW_FWD, 46079, 0, 0, 0, 0},
		'{KIND_ROTATE, AXIS_YAW_FWD, -46080, 0, 0, 0, 0},
		'{KIND_ROTATE, AXIS_PITCH_RIGHT, 5760, 0, 0, 0, 0},
		'{KIND_ROTATE, AXIS_YAW_FWD, 1, 0, 0, 0, 0},
		'{KIND_MOVE, AXIS_ROLL_UP, 0, -1, 0, 0, 0},
		'{KIND_ROTATE, AXIS_ROLL_UP, 123, 0, 0, 0, 0}
	};

	logic clk;
	logic arst_n;
	fcvm_in_if cmd_ch();
	fcvm_out_if row_ch();

	fly_camera_view_matrix_unit DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd_ch),
		.row(row_ch)
	);

	longint cam_yaw;
	longint cam_pitch;
	longint cam_pos [3];
	longint cam_basis [9];
	row_word_t pending_rows [$];
	int mismatches;
	int words_checked;
	int degenerate_words;
	int cycle_count;
	bit hold_long;
	bit quiet_mode;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	task automatic flag_mismatch(string field, longint got, longint want);
		$display("mismatch on %s: got %0d, expected %0d at cycle %0d", field, got, want,
			cycle_count);
		mismatches++;
	endtask

	function automatic longint unsigned taylor_series(longint unsigned x2, bit cos_sel);
		int unsigned sin_div [5] = '{110, 72, 42, 20, 6};
		int unsigned cos_div [6] = '{132, 90, 56, 30, 12, 2};
		longint unsigned one;
		longint unsigned t;
		longint unsigned d;
		one = 64'd1 << 30;
		t = one;
		for (int i = 0; i < (cos_sel ? 6 : 5); i++) begin
			d = ((x2 * t) >> 30) / (cos_sel ? cos_div[i] : sin_div[i]);
			t = (d > one) ? 64'd0 : one - d;
		end
		return t;
	endfunction

	function automatic longint q30_to_vec(longint unsigned v);
		return longint'((v + (64'd1 << (29 - VecFracBits))) >> (30 - VecFracBits));
	endfunction

	function automatic longint round_frac(longint p);
		longint unsigned m;
		m = (p < 0) ? longint'(-p) : p;
		m = (m + (64'd1 << (VecFracBits - 1))) >> VecFracBits;
		return (p < 0) ? -longint'(m) : longint'(m);
	endfunction

	function automatic longint vec_mul(longint a, longint b);
		return round_frac(a * b);
	endfunction

	function automatic longint clamp32(longint v);
		if (v > 64'sd2147483647) return 64'sd2147483647;
		if (v < -64'sd2147483648) return -64'sd2147483648;
		return v;
	endfunction

	function automatic longint wrap_turn(longint a);
		longint v;
		v = a % Turn;
		return (v < 0) ? v + Turn : v;
	endfunction

	task automatic sin_cos(input longint a, output longint s, output longint c);
		longint q;
		longint unsigned x;
		longint unsigned x2;
		longint sv;
		longint cv;
		q = (a / Quarter) & 3;
		x = (longint'(a % Quarter) * 64'd18740330) >> AngleFracBits;
		x2 = (x * x) >> 30;
		sv = q30_to_vec((x * taylor_series(x2, 1'b0)) >> 30);
		cv = q30_to_vec(taylor_series(x2, 1'b1));
		case (q)
			0: begin s = sv; c = cv; end
			1: begin s = cv; c = -sv; end
			2: begin s = -sv; c = -cv; end
			default: begin s = -cv; c = sv; end
		endcase
	endtask

	task automatic apply_camera_command(kind_e kind, axis_e axis, longint delta,
		longint amount);
		longint sy, cy, sp, cp, sg, sum;
		longint rowv [3];
		bit degen;
		int base;
		row_word_t w;
		if (kind == KIND_ROTATE) begin
			if (axis == AXIS_YAW_FWD) cam_yaw = wrap_turn(cam_yaw + delta);
			else if (axis == AXIS_PITCH_RIGHT) cam_pitch = wrap_turn(cam_pitch + delta);
		end else if (axis != AXIS_NONE) begin
			for (int i = 0; i < 3; i++)
				cam_pos[i] = clamp32(cam_pos[i] + vec_mul(amount, cam_basis[int'(axis) * 3 + i]));
		end
		sin_cos(cam_yaw, sy, cy);
		sin_cos(cam_pitch, sp, cp);
		degen = (cp == 0);
		if (!degen) begin
			sg = (cp > 0) ? 1 : -1;
			cam_basis = '{vec_mul(cy, cp), sp, vec_mul(sy, cp), -sg * sy, 0, sg * cy,
				-sg * vec_mul(cy, sp), sg * cp, -sg * vec_mul(sy, sp)};
		end
		for (int k = 0; k < 3; k++) begin
			base = (k == 0) ? 3 : (k == 1) ? 6 : 0;
			sum = 0;
			for (int i = 0; i < 3; i++) begin
				rowv[i] = (k == 2) ? -cam_basis[base + i] : cam_basis[base + i];
				sum += rowv[i] * cam_pos[i];
			end
			w.row_index = 2'(k);
			w.coef_x = vec_t'(rowv[0]);
			w.coef_y = vec_t'(rowv[1]);
			w.coef_z = vec_t'(rowv[2]);
			w.translation = pos_t'(clamp32(-round_frac(sum)));
			w.degenerate = degen;
			w.last_row = (k == int'(RowLast));
			pending_rows.push_back(w);
		end
	endtask

	task automatic offer_command(kind_e kind, axis_e axis, int delta, int amount, int gap);
		if (gap > 0) begin
			cmd_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd_ch.kind <= kind;
		cmd_ch.which_axis <= axis;
		cmd_ch.angle_delta <= 17'(delta);
		cmd_ch.move_amount <= amount;
		cmd_ch.valid <= 1'b1;
		do @(posedge clk); while (!(cmd_ch.valid && cmd_ch.ready));
		apply_camera_command(kind, axis, delta, amount);
	endtask

	function automatic int draw_gap();
		return quiet_mode ? 0 : $urandom_range(0, 13);
	endfunction

	initial begin
		int pick;
		kind_e kind;
		axis_e axis;
		int delta;
		int amount;
		cmd_ch.valid = 1'b0;
		cmd_ch.kind = KIND_ROTATE;
		cmd_ch.which_axis = AXIS_YAW_FWD;
		cmd_ch.angle_delta = '0;
		cmd_ch.move_amount = '0;
		row_ch.ready = 1'b0;
		arst_n = 1'b0;
		mismatches = 0;
		words_checked = 0;
		degenerate_words = 0;
		hold_long = 1'b0;
		quiet_mode = 1'b0;
		cam_yaw = YawReset;
		cam_pitch = 0;
		cam_pos = '{0, 0, longint'(PosZReset)};
		cam_basis = '{0, 0, -longint'(VecOne), longint'(VecOne), 0, 0, 0, longint'(VecOne), 0};
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int n = 0; n < NumDirected; n++) begin
			offer_command(directed[n].kind, directed[n].axis, directed[n].delta,
				directed[n].amount, draw_gap());
			if (directed[n].known) begin
				for (int k = 0; k < 3; k++)
					pending_rows[pending_rows.size() - 3 + k].degenerate = directed[n].degen;
				pending_rows[pending_rows.size() - 1].translation = directed[n].back_trans;
			end
		end

		for (int n = 0; n < NumRandom; n++) begin
			quiet_mode = (n >= 100 && n < 140);
			hold_long = (n >= 200 && n < 203);
			if (n == 300) begin
				cmd_ch.valid <= 1'b0;
				while (pending_rows.size() != 0) @(posedge clk);
			end
			pick = $urandom_range(0, 99);
			delta = 0;
			amount = 0;
			if (pick < 45) begin
				kind = KIND_ROTATE;
				axis = ($urandom_range(0, 1) == 0) ? AXIS_YAW_FWD : AXIS_PITCH_RIGHT;
				if ($urandom_range(0, 9) < 2) delta = Quarter * ($urandom_range(0, 7) - 4);
				else delta = $urandom_range(0, 92159) - 46080;
			end else if (pick < 55) begin
				kind = $urandom_range(0, 1) ? KIND_MOVE : KIND_ROTATE;
				axis = $urandom_range(0, 1) ? AXIS_ROLL_UP : AXIS_NONE;
				delta = $urandom_range(0, 92159) - 46080;
				amount = $urandom;
			end else begin
				kind = KIND_MOVE;
				axis = axis_e'($urandom_range(0, 2));
				if ($urandom_range(0, 4) == 0) amount = $urandom;
				else amount = $urandom_range(0, 1 << 22) - (1 << 21);
				delta = $urandom_range(0, 92159) - 46080;
			end
			offer_command(kind, axis, delta, amount, (n == 300) ? 0 : draw_gap());
		end
		cmd_ch.valid <= 1'b0;

		while (pending_rows.size() != 0) @(posedge clk);
		repeat (300) @(posedge clk);
		$display("covered %0d commands, %0d row words checked, %0d with a vertical pitch",
			NumDirected + NumRandom, words_checked, degenerate_words);
		$display("rotations with wrap, roll and no-op axes, saturating moves, input stalls");
		if (mismatches == 0 && pending_rows.size() == 0) begin
			$display("fly_camera_view_matrix_unit verification clean");
		end else begin
			$display("fly_camera_view_matrix_unit verification failed");
		end
		$finish;
	end

	initial begin
		int stall;
		row_word_t w;
		@(posedge arst_n);
		forever begin
			stall = hold_long ? 400 : (quiet_mode ? 0 : $urandom_range(0, 13));
			if (stall > 0) begin
				row_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			row_ch.ready <= 1'b1;
			do @(posedge clk); while (!(row_ch.valid && row_ch.ready));
			if (pending_rows.size() == 0) begin
				flag_mismatch("unexpected row word", row_ch.row_index, -1);
			end else begin
				w = pending_rows.pop_front();
				words_checked++;
				if (row_ch.degenerate) degenerate_words++;
				if (row_ch.row_index !== w.row_index)
					flag_mismatch("row_index", row_ch.row_index, w.row_index);
				if (row_ch.coef_x !== w.coef_x) flag_mismatch("coef_x", row_ch.coef_x, w.coef_x);
				if (row_ch.coef_y !== w.coef_y) flag_mismatch("coef_y", row_ch.coef_y, w.coef_y);
				if (row_ch.coef_z !== w.coef_z) flag_mismatch("coef_z", row_ch.coef_z, w.coef_z);
				if (row_ch.translation !== w.translation)
					flag_mismatch("translation", row_ch.translation, w.translation);
				if (row_ch.degenerate !== w.degenerate)
					flag_mismatch("degenerate", row_ch.degenerate, w.degenerate);
				if (row_ch.last_row !== w.last_row)
					flag_mismatch("last_row", row_ch.last_row, w.last_row);
			end
		end
	end

	initial begin
		cycle_count = 0;
		while (cycle_count < CycleLimit) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("timeout after %0d cycles", cycle_count);
		$display("fly_camera_view_matrix_unit verification failed");
		$finish;
	end

endmodule

/* files.f */
src/fcvm_pkg.sv
src/fcvm_if.sv
src/fcvm_mul.sv
src/fly_camera_view_matrix_unit.sv
src/fcvm_checker.sv
dv/fly_camera_view_matrix_unit_tb.sv
